@@ hdl/gcr_pkg.sv @@
// gcr_pkg: shared constants, types and lookup functions of the grid column raycaster
// used by gcr_regs, gcr_ctrl, gcr_dp, gcr_checker and the top level; depends on nothing else
package gcr_pkg;

  // parameter defaults
  localparam int MAP_SIZE_DEF   = 16;
  localparam int ANGLE_BITS_DEF = 12;
  localparam int MAX_ROWS_DEF   = 64;

  // field widths
  localparam int COL_W   = 8;
  localparam int POS_W   = 12;
  localparam int HEAD_W  = 12;
  localparam int ROW_W   = 6;
  localparam int GLYPH_W = 4;
  localparam int DIST_W  = 10;
  localparam int FOV_W   = 12;
  localparam int COLS_W  = 8;
  localparam int ROWS_W  = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int MAP_BITS   = 256;

  // datapath widths
  localparam int DIV_W     = 20;
  localparam int DVS_W     = 11;
  localparam int DIV_STEPS = 20;
  localparam int CNT_W     = 5;
  localparam int SX_W      = 27;
  localparam int EYE_W     = 16;
  localparam int CEIL_W    = 12;
  localparam int CELL_UNITS = 163840;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAP_A = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_B = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_C = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FOV   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_COLS  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 3'd7;

  // register reset values
  localparam logic [FOV_W-1:0]    FOV_RST   = 12'd683;
  localparam logic [DIST_W-1:0]   DEPTH_RST = 10'd300;
  localparam logic [COLS_W-1:0]   COLS_RST  = 8'd120;
  localparam logic [ROWS_W-1:0]   ROWS_RST  = 7'd40;

  // glyph codes
  localparam logic [GLYPH_W-1:0] GLY_BLANK  = 4'd0;
  localparam logic [GLYPH_W-1:0] GLY_FULL   = 4'd1;
  localparam logic [GLYPH_W-1:0] GLY_DARK   = 4'd2;
  localparam logic [GLYPH_W-1:0] GLY_MEDIUM = 4'd3;
  localparam logic [GLYPH_W-1:0] GLY_LIGHT  = 4'd4;
  localparam logic [GLYPH_W-1:0] GLY_HASH   = 4'd5;
  localparam logic [GLYPH_W-1:0] GLY_X      = 4'd6;
  localparam logic [GLYPH_W-1:0] GLY_TILDE  = 4'd7;
  localparam logic [GLYPH_W-1:0] GLY_DASH   = 4'd8;

  typedef struct packed {
    logic [MAP_BITS-1:0] map_bits;
    logic [FOV_W-1:0]    fov;
    logic [DIST_W-1:0]   depth;
    logic [COLS_W-1:0]   cols;
    logic [ROWS_W-1:0]   rows;
  } cfg_t;

  typedef struct packed {
    logic load_in;
    logic div_ray_init;
    logic div_ceil_init;
    logic div_step;
    logic load_ray;
    logic sin_s1;
    logic sin_cos;
    logic load_eye_x;
    logic load_eye_y;
    logic march_init;
    logic march_step;
    logic march_clamp;
    logic load_ceil;
    logic emit_row;
  } cmd_t;

  typedef struct packed {
    logic off_map;
    logic wall;
    logic at_depth;
    logic rows_zero;
    logic out_free;
    logic row_last;
  } stat_t;

  // quarter-wave sine, Q1.14, 33 points
  function automatic logic [14:0] qsine(input logic [5:0] idx);
    logic [14:0] v;
    case (idx)
      6'd0:  v = 15'd0;     6'd1:  v = 15'd804;   6'd2:  v = 15'd1606;
      6'd3:  v = 15'd2404;  6'd4:  v = 15'd3196;  6'd5:  v = 15'd3981;
      6'd6:  v = 15'd4756;  6'd7:  v = 15'd5520;  6'd8:  v = 15'd6270;
      6'd9:  v = 15'd7005;  6'd10: v = 15'd7723;  6'd11: v = 15'd8423;
      6'd12: v = 15'd9102;  6'd13: v = 15'd9760;  6'd14: v = 15'd10394;
      6'd15: v = 15'd11003; 6'd16: v = 15'd11585; 6'd17: v = 15'd12140;
      6'd18: v = 15'd12665; 6'd19: v = 15'd13160; 6'd20: v = 15'd13623;
      6'd21: v = 15'd14053; 6'd22: v = 15'd14449; 6'd23: v = 15'd14811;
      6'd24: v = 15'd15137; 6'd25: v = 15'd15426; 6'd26: v = 15'd15679;
      6'd27: v = 15'd15893; 6'd28: v = 15'd16069; 6'd29: v = 15'd16207;
      6'd30: v = 15'd16305; 6'd31: v = 15'd16364;
      default: v = 15'd16384;
    endcase
    return v;
  endfunction

  // slope between neighboring table points
  function automatic logic [9:0] qsine_step(input logic [4:0] idx);
    logic [14:0] hi;
    logic [14:0] lo;
    hi = qsine({1'b0, idx} + 6'd1);
    lo = qsine({1'b0, idx});
    return 10'(hi - lo);
  endfunction

endpackage

@@ hdl/grid_column_raycaster_unit.sv @@
// grid column raycaster, one screen column per input beat, one glyph beat per screen row
// hit distance d = march steps taken (1..max_depth_steps); a new column is taken only once
// every row of the previous one is emitted; the march loop takes one step per cycle and
// the shared divider runs twice per item
// rows then leave at one per cycle while the output is not stalled
// synchronous active-low reset clears the sequencer, output valid and config to defaults
module grid_column_raycaster_unit #(
  parameter int MAP_SIZE   = gcr_pkg::MAP_SIZE_DEF,
  parameter int ANGLE_BITS = gcr_pkg::ANGLE_BITS_DEF,
  parameter int MAX_ROWS   = gcr_pkg::MAX_ROWS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [gcr_pkg::COL_W-1:0]        in_column,
  input  logic [gcr_pkg::POS_W-1:0]        in_player_x,
  input  logic [gcr_pkg::POS_W-1:0]        in_player_y,
  input  logic [gcr_pkg::HEAD_W-1:0]       in_heading,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [gcr_pkg::ROW_W-1:0]        out_row,
  output logic [gcr_pkg::GLYPH_W-1:0]      out_glyph,
  output logic [gcr_pkg::DIST_W-1:0]       out_hit_distance,
  output logic                             out_last_row,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gcr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gcr_pkg::CFG_DATA_W-1:0]   cfg_data
);

  gcr_pkg::cfg_t  cfg;
  gcr_pkg::cmd_t  cmd;
  gcr_pkg::stat_t stat;

  gcr_regs u_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gcr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  gcr_dp #(
    .MAP_SIZE   (MAP_SIZE),
    .ANGLE_BITS (ANGLE_BITS),
    .MAX_ROWS   (MAX_ROWS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg              (cfg),
    .in_column        (in_column),
    .in_player_x      (in_player_x),
    .in_player_y      (in_player_y),
    .in_heading       (in_heading),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_row          (out_row),
    .out_glyph        (out_glyph),
    .out_hit_distance (out_hit_distance),
    .out_last_row     (out_last_row)
  );

endmodule

@@ hdl/gcr_regs.sv @@
// gcr_regs: configuration register file of the grid column raycaster
// depends on gcr_pkg for widths, register indexes and reset values
module gcr_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [gcr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [gcr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output gcr_pkg::cfg_t                    cfg
);

  logic [63:0]                  map_a_r, map_b_r, map_c_r, map_d_r;
  logic [gcr_pkg::FOV_W-1:0]    fov_r;
  logic [gcr_pkg::DIST_W-1:0]   depth_r;
  logic [gcr_pkg::COLS_W-1:0]   cols_r;
  logic [gcr_pkg::ROWS_W-1:0]   rows_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_a_r <= '0;
      map_b_r <= '0;
      map_c_r <= '0;
      map_d_r <= '0;
      fov_r   <= gcr_pkg::FOV_RST;
      depth_r <= gcr_pkg::DEPTH_RST;
      cols_r  <= gcr_pkg::COLS_RST;
      rows_r  <= gcr_pkg::ROWS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gcr_pkg::REG_MAP_A: map_a_r <= cfg_data;
        gcr_pkg::REG_MAP_B: map_b_r <= cfg_data;
        gcr_pkg::REG_MAP_C: map_c_r <= cfg_data;
        gcr_pkg::REG_MAP_D: map_d_r <= cfg_data;
        gcr_pkg::REG_FOV:   fov_r   <= cfg_data[gcr_pkg::FOV_W-1:0];
        gcr_pkg::REG_DEPTH: depth_r <= cfg_data[gcr_pkg::DIST_W-1:0];
        gcr_pkg::REG_COLS:  cols_r  <= cfg_data[gcr_pkg::COLS_W-1:0];
        gcr_pkg::REG_ROWS:  rows_r  <= cfg_data[gcr_pkg::ROWS_W-1:0];
        default: ;
      endcase
    end
  end

  // map row r lands at bits 16r .. 16r+15
  assign cfg.map_bits = {map_d_r, map_c_r, map_b_r, map_a_r};
  assign cfg.fov      = fov_r;
  assign cfg.depth    = depth_r;
  assign cfg.cols     = cols_r;
  assign cfg.rows     = rows_r;

endmodule

@@ hdl/gcr_ctrl.sv @@
// gcr_ctrl: sequencer of the grid column raycaster
// drives gcr_dp through gcr_pkg::cmd_t and reads gcr_pkg::stat_t back
module gcr_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  gcr_pkg::stat_t  stat,
  output gcr_pkg::cmd_t   cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_DIVR  = 4'd2;
  localparam logic [3:0] S_RAY   = 4'd3;
  localparam logic [3:0] S_SIN1  = 4'd4;
  localparam logic [3:0] S_SIN2  = 4'd5;
  localparam logic [3:0] S_COS1  = 4'd6;
  localparam logic [3:0] S_COS2  = 4'd7;
  localparam logic [3:0] S_MINIT = 4'd8;
  localparam logic [3:0] S_MARCH = 4'd9;
  localparam logic [3:0] S_CNUM  = 4'd10;
  localparam logic [3:0] S_DIVC  = 4'd11;
  localparam logic [3:0] S_CEIL  = 4'd12;
  localparam logic [3:0] S_EMIT  = 4'd13;

  localparam logic [gcr_pkg::CNT_W-1:0] CNT_LAST = gcr_pkg::CNT_W'(gcr_pkg::DIV_STEPS - 1);

  logic [3:0]                  state_r, state_nxt;
  logic [gcr_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.div_ray_init = 1'b1;
        cnt_nxt          = '0;
        state_nxt        = S_DIVR;
      end
      S_DIVR: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) state_nxt = S_RAY;
      end
      S_RAY: begin
        cmd.load_ray = 1'b1;
        state_nxt    = S_SIN1;
      end
      S_SIN1: begin
        cmd.sin_s1 = 1'b1;
        state_nxt  = S_SIN2;
      end
      S_SIN2: begin
        cmd.load_eye_x = 1'b1;
        state_nxt      = S_COS1;
      end
      S_COS1: begin
        cmd.sin_s1  = 1'b1;
        cmd.sin_cos = 1'b1;
        state_nxt   = S_COS2;
      end
      S_COS2: begin
        cmd.load_eye_y = 1'b1;
        state_nxt      = S_MINIT;
      end
      S_MINIT: begin
        cmd.march_init = 1'b1;
        state_nxt      = S_MARCH;
      end
      S_MARCH: begin
        // leaving the map counts as reaching full depth
        if (stat.off_map) begin
          cmd.march_clamp = 1'b1;
          state_nxt       = S_CNUM;
        end else if (stat.wall || stat.at_depth) begin
          state_nxt = S_CNUM;
        end else begin
          cmd.march_step = 1'b1;
        end
      end
      S_CNUM: begin
        cmd.div_ceil_init = 1'b1;
        cnt_nxt           = '0;
        state_nxt         = S_DIVC;
      end
      S_DIVC: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) state_nxt = S_CEIL;
      end
      S_CEIL: begin
        cmd.load_ceil = 1'b1;
        state_nxt     = stat.rows_zero ? S_IDLE : S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.emit_row = 1'b1;
          if (stat.row_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ hdl/gcr_dp.sv @@
// gcr_dp: datapath of the grid column raycaster: divider, sine unit, ray marcher,
// row shader and output register; depends on gcr_pkg, commanded by gcr_ctrl
module gcr_dp #(
  parameter int MAP_SIZE   = gcr_pkg::MAP_SIZE_DEF,
  parameter int ANGLE_BITS = gcr_pkg::ANGLE_BITS_DEF,
  parameter int MAX_ROWS   = gcr_pkg::MAX_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  gcr_pkg::cmd_t                   cmd,
  output gcr_pkg::stat_t                  stat,
  input  gcr_pkg::cfg_t                   cfg,
  input  logic [gcr_pkg::COL_W-1:0]       in_column,
  input  logic [gcr_pkg::POS_W-1:0]       in_player_x,
  input  logic [gcr_pkg::POS_W-1:0]       in_player_y,
  input  logic [gcr_pkg::HEAD_W-1:0]      in_heading,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [gcr_pkg::ROW_W-1:0]       out_row,
  output logic [gcr_pkg::GLYPH_W-1:0]     out_glyph,
  output logic [gcr_pkg::DIST_W-1:0]      out_hit_distance,
  output logic                            out_last_row
);

  localparam int ABW     = ANGLE_BITS;
  localparam int SX_W    = gcr_pkg::SX_W;
  localparam int EYE_W   = gcr_pkg::EYE_W;
  localparam int CEIL_W  = gcr_pkg::CEIL_W;
  localparam int DIV_W   = gcr_pkg::DIV_W;
  localparam int DVS_W   = gcr_pkg::DVS_W;
  localparam int AMASK   = (1 << ANGLE_BITS) - 1;
  localparam int QUARTER = 1 << (ANGLE_BITS - 2);
  localparam logic signed [SX_W-1:0] NEG_LIM = SX_W'(-gcr_pkg::CELL_UNITS);
  localparam logic signed [SX_W-1:0] POS_LIM = SX_W'(MAP_SIZE * gcr_pkg::CELL_UNITS);

  // effective configuration
  logic [gcr_pkg::FOV_W-1:0]   fov_eff;
  logic [gcr_pkg::COLS_W-1:0]  cols_eff;
  logic [gcr_pkg::DIST_W-1:0]  depth_eff;
  logic [gcr_pkg::ROWS_W-1:0]  h_eff;

  assign fov_eff   = cfg.fov & gcr_pkg::FOV_W'(AMASK);
  assign cols_eff  = (cfg.cols == '0) ? 8'd1 : cfg.cols;
  assign depth_eff = (cfg.depth == '0) ? 10'd1 : cfg.depth;
  assign h_eff     = (cfg.rows > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : cfg.rows;

  // captured item
  logic [gcr_pkg::COL_W-1:0]  column_r;
  logic [gcr_pkg::POS_W-1:0]  px_r, py_r;
  logic [gcr_pkg::HEAD_W-1:0] head_r;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      column_r <= in_column;
      px_r     <= in_player_x;
      py_r     <= in_player_y;
      head_r   <= in_heading;
    end
  end

  // shared restoring divider, one quotient bit per cycle
  logic [DIV_W-1:0]  quo_r;
  logic [DVS_W-1:0]  rem_r, dvs_r;
  logic              neg_r;
  logic [DVS_W+1:0]  trial;
  logic [DIV_W-1:0]  ray_prod;
  logic [gcr_pkg::DIST_W-1:0] d_r;
  logic signed [DVS_W-1:0]  dsub;
  logic signed [18:0]       cnum;
  logic [18:0]              cnum_abs;

  assign trial    = {1'b0, rem_r, quo_r[DIV_W-1]} - {2'b00, dvs_r};
  assign ray_prod = DIV_W'(column_r) * DIV_W'(fov_eff);
  assign dsub     = $signed({1'b0, d_r}) - 11'sd20;
  assign cnum     = 19'($signed({1'b0, h_eff})) * 19'(dsub);
  assign cnum_abs = cnum[18] ? 19'(-cnum) : 19'(cnum);

  always_ff @(posedge clk) begin
    if (cmd.div_ray_init) begin
      quo_r <= ray_prod;
      rem_r <= '0;
      dvs_r <= DVS_W'(cols_eff);
    end else if (cmd.div_ceil_init) begin
      quo_r <= DIV_W'(cnum_abs);
      rem_r <= '0;
      dvs_r <= {d_r, 1'b0};
      neg_r <= cnum[18];
    end else if (cmd.div_step) begin
      if (!trial[DVS_W+1]) begin
        rem_r <= trial[DVS_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= {rem_r[DVS_W-2:0], quo_r[DIV_W-1]};
        quo_r <= {quo_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  // ray angle
  logic [ABW-1:0] ray_r;

  always_ff @(posedge clk) begin
    if (cmd.load_ray)
      ray_r <= ABW'(head_r) - ABW'(fov_eff >> 1) + quo_r[ABW-1:0];
  end

  // sine unit: table and slope product, then interpolate and sign
  logic [ABW-1:0]  ang;
  logic [15:0]     a16;
  logic [14:0]     p;
  logic [5:0]      sidx;
  logic [8:0]      frac;
  logic [14:0]     sb_base_r;
  logic [18:0]     sb_prod_r;
  logic            sb_full_r, sb_neg_r;
  logic [14:0]     smag;
  logic signed [EYE_W-1:0] sval;
  logic signed [EYE_W-1:0] eye_x_r, eye_y_r;

  assign ang  = cmd.sin_cos ? ray_r + ABW'(QUARTER) : ray_r;
  assign a16  = 16'(ang) << (16 - ANGLE_BITS);
  assign p    = a16[14] ? (15'h4000 - {1'b0, a16[13:0]}) : {1'b0, a16[13:0]};
  assign sidx = p[14:9];
  assign frac = p[8:0];

  always_ff @(posedge clk) begin
    if (cmd.sin_s1) begin
      sb_base_r <= gcr_pkg::qsine(sidx);
      sb_prod_r <= 19'(gcr_pkg::qsine_step(sidx[4:0])) * 19'(frac);
      sb_full_r <= sidx[5];
      sb_neg_r  <= a16[15];
    end
  end

  assign smag = sb_full_r ? 15'd16384 : sb_base_r + 15'(sb_prod_r >> 9);
  assign sval = sb_neg_r ? -$signed({1'b0, smag}) : $signed({1'b0, smag});

  always_ff @(posedge clk) begin
    if (cmd.load_eye_x) eye_x_r <= sval;
    if (cmd.load_eye_y) eye_y_r <= sval;
  end

  // ray march, sample point in 1/163840 cell units
  logic signed [SX_W-1:0] sx_r, sy_r;
  logic signed [SX_W-1:0] px_base, py_base;
  logic [4:0] cx, cy;

  assign px_base = $signed(SX_W'({px_r, 9'b0}) + SX_W'({px_r, 7'b0}));
  assign py_base = $signed(SX_W'({py_r, 9'b0}) + SX_W'({py_r, 7'b0}));

  // returns {off map, cell}; cell = (s >> 15) / 5 via reciprocal 205/1024
  function automatic logic [4:0] cell_of(input logic signed [SX_W-1:0] s);
    logic [6:0]  t;
    logic [14:0] q;
    logic [4:0]  r;
    t = s[21:15];
    q = 15'(t) * 15'd205;
    if (s <= NEG_LIM)      r = {1'b1, 4'd0};
    else if (s < 0)        r = {1'b0, 4'd0};
    else if (s >= POS_LIM) r = {1'b1, 4'd0};
    else                   r = {1'b0, q[13:10]};
    return r;
  endfunction

  assign cx = cell_of(sx_r);
  assign cy = cell_of(sy_r);

  always_ff @(posedge clk) begin
    if (cmd.march_init) begin
      sx_r <= px_base + SX_W'(eye_x_r);
      sy_r <= py_base + SX_W'(eye_y_r);
      d_r  <= 10'd1;
    end else if (cmd.march_step) begin
      sx_r <= sx_r + SX_W'(eye_x_r);
      sy_r <= sy_r + SX_W'(eye_y_r);
      d_r  <= d_r + 10'd1;
    end else if (cmd.march_clamp) begin
      d_r <= depth_eff;
    end
  end

  assign stat.off_map  = cx[4] | cy[4];
  assign stat.wall     = cfg.map_bits[{cy[3:0], cx[3:0]}];
  assign stat.at_depth = (d_r == depth_eff);

  // ceiling and floor rows
  logic signed [CEIL_W-1:0] ceil_r, floor_r, ceil_val;

  assign ceil_val = neg_r ? -$signed({2'b00, quo_r[9:0]}) : $signed({2'b00, quo_r[9:0]});

  always_ff @(posedge clk) begin
    if (cmd.load_ceil) begin
      ceil_r  <= ceil_val;
      floor_r <= $signed({5'b0, h_eff}) - ceil_val;
    end
  end

  // row shading
  logic [gcr_pkg::ROW_W-1:0]    y_r;
  logic signed [CEIL_W-1:0]     y_s;
  logic [11:0]                  m, hh, dd, dep;
  logic [gcr_pkg::GLYPH_W-1:0]  shade, floor_g, glyph;

  assign y_s = $signed({6'b0, y_r});
  assign m   = 12'(h_eff - 7'(y_r));
  assign hh  = 12'(h_eff);
  assign dd  = 12'(d_r);
  assign dep = 12'(depth_eff);

  always_comb begin
    if (3 * dd <= dep)           shade = gcr_pkg::GLY_FULL;
    else if (2 * dd < dep)       shade = gcr_pkg::GLY_DARK;
    else if (3 * dd < 2 * dep)   shade = gcr_pkg::GLY_MEDIUM;
    else if (dd < dep)           shade = gcr_pkg::GLY_LIGHT;
    else                         shade = gcr_pkg::GLY_BLANK;

    if (8 * m < hh)              floor_g = gcr_pkg::GLY_HASH;
    else if (4 * m < hh)         floor_g = gcr_pkg::GLY_X;
    else if (8 * m < 3 * hh)     floor_g = gcr_pkg::GLY_TILDE;
    else if (20 * m < 9 * hh)    floor_g = gcr_pkg::GLY_DASH;
    else                         floor_g = gcr_pkg::GLY_BLANK;

    if (y_s <= ceil_r)           glyph = gcr_pkg::GLY_BLANK;
    else if (y_s <= floor_r)     glyph = shade;
    else                         glyph = floor_g;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_ceil)     y_r <= '0;
    else if (cmd.emit_row) y_r <= y_r + 1'b1;
  end

  assign stat.rows_zero = (h_eff == '0);
  assign stat.row_last  = ((7'(y_r) + 7'd1) == h_eff);

  // output register
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n)             out_valid_r <= 1'b0;
    else if (cmd.emit_row)  out_valid_r <= 1'b1;
    else if (!out_stall)    out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_row) begin
      out_row          <= y_r;
      out_glyph        <= glyph;
      out_hit_distance <= d_r;
      out_last_row     <= stat.row_last;
    end
  end

  assign out_valid     = out_valid_r;
  assign stat.out_free = !out_valid_r || !out_stall;

endmodule

@@ hdl/gcr_checker.sv @@
// gcr_checker: port-level assertions for grid_column_raycaster_unit, bound to the top level
// depends on gcr_pkg for port widths
module gcr_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [gcr_pkg::ROW_W-1:0]        out_row,
  input logic [gcr_pkg::GLYPH_W-1:0]      out_glyph,
  input logic [gcr_pkg::DIST_W-1:0]       out_hit_distance,
  input logic                             out_last_row
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_row) && $stable(out_glyph)
      && $stable(out_hit_distance) && $stable(out_last_row))
    else $error("stalled result beat changed");

  // an accepted column keeps the input side busy while it is cast
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after a beat");

  // while a new column can be taken only the previous last row may still wait
  a_idle_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !in_stall |-> out_last_row)
    else $error("input open while rows of a column are pending");

  // every ray takes at least one step
  a_dist_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hit_distance != '0)
    else $error("zero hit distance on a result beat");

endmodule

bind grid_column_raycaster_unit gcr_checker u_chk (.*);
